[src/sqrr_pkg.sv]
// Shared codes and sizes of the symmetric quartic root solver.
`default_nettype none
package sqrr_pkg;

   localparam logic STATUS_SOLVED  = 1'b0;
   localparam logic STATUS_NOT_SYM = 1'b1;

   localparam int ROOT_SLOTS = 4;
   localparam int COUNT_BITS = 3;

endpackage
`default_nettype wire

[src/sqrr_sqrt_pipe.sv]
// Pipelined exact integer square root, one root bit per register stage.
`default_nettype none
module sqrr_sqrt_pipe
   import sqrr_pkg::*;
#(
   parameter int IN_W = 8
) (
   input  wire logic                  clock,
   input  wire logic                  en,
   input  wire logic [IN_W-1:0]       radicand,
   output logic      [IN_W/2-1:0]     root,
   output logic                       exact
);

   localparam int RTW = IN_W / 2;

   logic [IN_W-1:0] rem_ff  [1:RTW];
   logic [RTW-1:0]  root_ff [1:RTW];
   logic [IN_W-1:0] rem_w   [0:RTW];
   logic [RTW-1:0]  root_w  [0:RTW];

   assign rem_w[0]  = radicand;
   assign root_w[0] = '0;

   for (genvar i = 0; i < RTW; i++) begin : g_stage
      localparam int B = RTW - 1 - i;
      logic [IN_W:0] trial;
      logic          take;

      // trial = (r + 2^B)^2 - r^2
      always_comb begin
         trial = ((IN_W+1)'(root_w[i]) << (B + 1)) | ((IN_W+1)'(1) << (2 * B));
         take  = (IN_W+1)'(rem_w[i]) >= trial;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i+1]  <= take ? IN_W'((IN_W+1)'(rem_w[i]) - trial) : rem_w[i];
            root_ff[i+1] <= take ? (root_w[i] | (RTW'(1) << B)) : root_w[i];
         end
      end

      assign rem_w[i+1]  = rem_ff[i+1];
      assign root_w[i+1] = root_ff[i+1];
   end

   assign root  = root_w[RTW];
   assign exact = (rem_w[RTW] == '0);

endmodule
`default_nettype wire

[src/symmetric_quartic_real_roots.sv]
// Top level of the pipelined real-root solver for symmetric quartics.
`default_nettype none
// Solves a*x^4+b*x^3+c*x^2+b*x+a = 0 for signed fixed-point coefficients
// (WORD_BITS wide, FRAC_BITS fraction bits) and returns up to four real
// roots, rounded to nearest, saturated to the word range with a flag. A zero
// a is answered with status NOT_SYM and all fields zero. The block is a
// fixed pipeline (Q16.16 by default): one word is taken every cycle while
// the result register is not stalled, and its depth is set by three
// bit-per-stage units in series: the square root of the discriminant, the
// divider that forms z, and the square roots of z^2-4. The whole pipeline
// holds while the result register is full and not taken.
module symmetric_quartic_real_roots
   import sqrr_pkg::*;
#(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_tvalid,
   output logic                                         req_tready,
   // coef_a, coef_b, coef_c, zero pad
   input  wire logic [((3*WORD_BITS+7)/8)*8-1:0]        req_tdata,
   output logic                                         rsp_tvalid,
   input  wire logic                                    rsp_tready,
   // root_count, root_1, root_2, root_3, root_4, saturated, zero pad
   output logic [((4*WORD_BITS+COUNT_BITS+1+7)/8)*8-1:0] rsp_tdata,
   // status
   output logic                                         rsp_tuser
);

   localparam int W        = WORD_BITS;
   localparam int F        = FRAC_BITS;
   localparam int OUT_BITS = ((4*W+COUNT_BITS+1+7)/8)*8;
   localparam int DW       = 2*W + 5;
   localparam int QW       = 2*W + 2*F + 6;
   localparam int RW       = QW / 2;
   localparam int YW       = W + F + 5;
   localparam int MW       = W + 2;
   localparam int HW       = (YW + 1) / 2;
   localparam int LW       = YW - HW;
   localparam int EW       = 2 * YW;
   localparam int CLW      = (YW > 64) ? YW : 64;
   localparam int XW       = YW + 3;

   localparam logic [CLW-1:0]       ZLIM = CLW'(1) << 62;
   localparam logic [EW-1:0]        FOUR = EW'(1) << (2*F + 2);
   localparam logic signed [XW-1:0] MAXV = XW'({1'b0, {(W-1){1'b1}}});
   localparam logic signed [XW-1:0] MINV = -MAXV - XW'(1);

   typedef struct packed {
      logic         valid;
      logic         st;
      logic         has_z;
      logic         two_z;
      logic         a_neg;
      logic [W-1:0] absa;
      logic [W-1:0] b;
   } sd_type;

   typedef struct packed {
      logic          valid;
      logic          st;
      logic          has_z;
      logic          two_z;
      logic [1:0]    neg;
      logic [MW-1:0] m2;
   } dv_type;

   typedef struct packed {
      logic valid;
      logic st;
      logic has_z;
      logic two_z;
   } zs_type;

   typedef struct packed {
      logic          valid;
      logic          st;
      logic          has_z;
      logic          two_z;
      logic [1:0]    gt;
      logic [1:0]    eq;
      logic [YW:0]   zq1;
      logic [YW:0]   zq0;
   } xs_type;

   logic en;
   logic rsp_tvalid_ff;

   assign en         = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = en;

   // ---------------- front end: products and discriminant
   logic                   v1_ff, st1_ff;
   logic signed [W-1:0]    a1_ff, b1_ff;
   logic signed [W+1:0]    c21_ff;
   logic signed [W-1:0]    a_in, b_in, c_in;

   assign a_in = signed'(req_tdata[W-1:0]);
   assign b_in = signed'(req_tdata[2*W-1:W]);
   assign c_in = signed'(req_tdata[3*W-1:2*W]);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid;
      end
      if (en) begin
         st1_ff <= (a_in == '0);
         a1_ff  <= a_in;
         b1_ff  <= b_in;
         c21_ff <= (W+2)'(c_in) - ((W+2)'(a_in) <<< 1);
      end
   end

   logic                   v2_ff, st2_ff;
   logic signed [W-1:0]    a2_ff, b2_ff;
   logic signed [2*W-1:0]  bb2_ff;
   logic signed [2*W+1:0]  ac2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
      if (en) begin
         st2_ff <= st1_ff;
         a2_ff  <= a1_ff;
         b2_ff  <= b1_ff;
         bb2_ff <= b1_ff * b1_ff;
         ac2_ff <= (2*W+2)'(a1_ff) * (2*W+2)'(c21_ff);
      end
   end

   logic signed [DW-1:0] dn;
   logic [QW-1:0]        q3_ff;
   sd_type               sd3_ff;

   assign dn = DW'(bb2_ff) - (DW'(ac2_ff) <<< 2);

   always_ff @(posedge clock) begin
      if (reset) begin
         sd3_ff.valid <= 1'b0;
      end else if (en) begin
         sd3_ff.valid <= v2_ff;
      end
      if (en) begin
         sd3_ff.st    <= st2_ff;
         sd3_ff.has_z <= !st2_ff && !dn[DW-1];
         sd3_ff.two_z <= (dn != '0);
         sd3_ff.a_neg <= a2_ff[W-1];
         sd3_ff.absa  <= a2_ff[W-1] ? W'(-a2_ff) : W'(a2_ff);
         sd3_ff.b     <= b2_ff;
         q3_ff        <= dn[DW-1] ? '0 : (QW'(dn[DW-2:0]) << (2*F + 2));
      end
   end

   // ---------------- square root of the scaled discriminant
   logic [RW-1:0] root_q;
   logic          exact_q;
   sd_type        s_ff [RW];

   sqrr_sqrt_pipe #(.IN_W(QW)) u_sqrt_d (
      .clock    (clock),
      .en       (en),
      .radicand (q3_ff),
      .root     (root_q),
      .exact    (exact_q)
   );

   for (genvar i = 0; i < RW; i++) begin : g_sd
      always_ff @(posedge clock) begin
         if (reset) begin
            s_ff[i].valid <= 1'b0;
         end else if (en) begin
            s_ff[i] <= (i == 0) ? sd3_ff : s_ff[(i == 0) ? 0 : i-1];
         end
      end
   end

   // ---------------- numerators of z for both branches
   sd_type               sy;
   logic signed [YW-1:0] sbx, k, rx, y_add, y_sub;
   logic signed [YW-1:0] y [2];
   logic signed [YW-1:0] m2x;

   logic [YW-1:0] dnum_ff [2][YW+1];
   logic [MW-1:0] drem_ff [2][YW+1];
   dv_type        dv_ff   [YW+1];

   always_comb begin
      sy    = s_ff[RW-1];
      sbx   = sy.a_neg ? -YW'(signed'(sy.b)) : YW'(signed'(sy.b));
      k     = -(sbx <<< (F + 1)) + YW'({sy.absa, 1'b0});
      rx    = YW'(root_q);
      y_add = k + rx;
      y_sub = k - rx - YW'(!exact_q);
      y[0]  = sy.a_neg ? y_sub : y_add;
      y[1]  = sy.a_neg ? y_add : y_sub;
      m2x   = YW'({sy.absa, 2'b00});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0].valid <= 1'b0;
      end else if (en) begin
         dv_ff[0].valid <= sy.valid;
      end
      if (en) begin
         dv_ff[0].st    <= sy.st;
         dv_ff[0].has_z <= sy.has_z;
         dv_ff[0].two_z <= sy.two_z;
         dv_ff[0].m2    <= {sy.absa, 2'b00};
         for (int j = 0; j < 2; j++) begin
            dv_ff[0].neg[j] <= y[j][YW-1];
            // floor division of a negative value: divide (|y| + m - 1)
            dnum_ff[j][0]   <= y[j][YW-1] ? YW'(-y[j] + m2x - YW'(1)) : YW'(y[j]);
            drem_ff[j][0]   <= '0;
         end
      end
   end

   // ---------------- restoring dividers, one quotient bit per stage
   for (genvar i = 0; i < YW; i++) begin : g_div
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[i+1].valid <= 1'b0;
         end else if (en) begin
            dv_ff[i+1] <= dv_ff[i];
         end
      end
      for (genvar j = 0; j < 2; j++) begin : g_br
         logic [MW:0] t;
         logic        ge;
         always_comb begin
            t  = {drem_ff[j][i], dnum_ff[j][i][YW-1]};
            ge = t >= {1'b0, dv_ff[i].m2};
         end
         always_ff @(posedge clock) begin
            if (en) begin
               drem_ff[j][i+1] <= ge ? MW'(t - {1'b0, dv_ff[i].m2}) : MW'(t);
               dnum_ff[j][i+1] <= {dnum_ff[j][i][YW-2:0], ge};
            end
         end
      end
   end

   // ---------------- clip and sign z, then square it
   zs_type              zz_ff, zp_ff, zt_ff;
   logic [YW-1:0]       za_ff  [2];
   logic signed [YW:0]  zq_ff  [2];
   logic signed [YW:0]  zqp_ff [2];
   logic signed [YW:0]  zqt_ff [2];
   logic [2*LW-1:0]     hh_ff  [2];
   logic [LW+HW-1:0]    hl_ff  [2];
   logic [2*HW-1:0]     ll_ff  [2];
   logic [EW-1:0]       e_ff   [2];
   logic                gt_ff  [2];
   logic                eq_ff  [2];

   always_ff @(posedge clock) begin
      if (reset) begin
         zz_ff.valid <= 1'b0;
         zp_ff.valid <= 1'b0;
         zt_ff.valid <= 1'b0;
      end else if (en) begin
         zz_ff <= '{valid: dv_ff[YW].valid, st: dv_ff[YW].st,
                    has_z: dv_ff[YW].has_z, two_z: dv_ff[YW].two_z};
         zp_ff <= zz_ff;
         zt_ff <= zp_ff;
      end
   end

   for (genvar j = 0; j < 2; j++) begin : g_zsq
      logic [YW-1:0]   q, za;
      logic [EW-1:0]   z2;
      logic [LW-1:0]   zh;
      logic [HW-1:0]   zl;
      always_comb begin
         q  = dnum_ff[j][YW];
         za = (CLW'(q) > ZLIM) ? YW'(ZLIM) : q;
         zh = za_ff[j][YW-1:HW];
         zl = za_ff[j][HW-1:0];
         z2 = (EW'(hh_ff[j]) << (2*HW)) + (EW'(hl_ff[j]) << (HW + 1)) + EW'(ll_ff[j]);
      end
      always_ff @(posedge clock) begin
         if (en) begin
            za_ff[j]  <= za;
            zq_ff[j]  <= dv_ff[YW].neg[j] ? -(YW+1)'(za) : (YW+1)'(za);
            hh_ff[j]  <= zh * zh;
            hl_ff[j]  <= (LW+HW)'(zh) * (LW+HW)'(zl);
            ll_ff[j]  <= zl * zl;
            zqp_ff[j] <= zq_ff[j];
            zqt_ff[j] <= zqp_ff[j];
            gt_ff[j]  <= z2 > FOUR;
            eq_ff[j]  <= z2 == FOUR;
            e_ff[j]   <= (z2 > FOUR) ? (z2 - FOUR) : '0;
         end
      end
   end

   // ---------------- square roots of z^2 - 4
   logic [YW-1:0] root_e  [2];
   logic          exact_e [2];
   xs_type        x_ff [YW];

   for (genvar j = 0; j < 2; j++) begin : g_xsqrt
      sqrr_sqrt_pipe #(.IN_W(EW)) u_sqrt_x (
         .clock    (clock),
         .en       (en),
         .radicand (e_ff[j]),
         .root     (root_e[j]),
         .exact    (exact_e[j])
      );
   end

   for (genvar i = 0; i < YW; i++) begin : g_xs
      always_ff @(posedge clock) begin
         if (reset) begin
            x_ff[i].valid <= 1'b0;
         end else if (en) begin
            if (i == 0) begin
               x_ff[i] <= '{valid: zt_ff.valid, st: zt_ff.st, has_z: zt_ff.has_z,
                            two_z: zt_ff.two_z, gt: {gt_ff[1], gt_ff[0]},
                            eq: {eq_ff[1], eq_ff[0]},
                            zq1: zqt_ff[1], zq0: zqt_ff[0]};
            end else begin
               x_ff[i] <= x_ff[(i == 0) ? 0 : i-1];
            end
         end
      end
   end

   // ---------------- roots, ordering and saturation
   function automatic logic [W:0] clip_word(input logic signed [XW-1:0] x);
      logic [W:0] res;
      if (x > MAXV) begin
         res = {1'b1, MAXV[W-1:0]};
      end else if (x < MINV) begin
         res = {1'b1, MINV[W-1:0]};
      end else begin
         res = {1'b0, x[W-1:0]};
      end
      return res;
   endfunction

   xs_type             xf;
   logic [1:0]         cnt [2];
   logic [W:0]         xa  [2];
   logic [W:0]         xb  [2];
   logic [W:0]         slot [ROOT_SLOTS];
   logic [COUNT_BITS-1:0] count;
   logic               sat;

   always_comb begin
      logic signed [XW-1:0] zx, zp1, h, r1, r2, cr, dbl;
      xf = x_ff[YW-1];
      for (int j = 0; j < 2; j++) begin
         zx  = (j == 0) ? XW'(signed'(xf.zq0)) : XW'(signed'(xf.zq1));
         zp1 = zx + XW'(1);
         h   = zp1 >>> 1;
         cr  = XW'(root_e[j]) + XW'(!exact_e[j]);
         r1  = h + XW'(root_e[j] >> 1) + XW'(zp1[0] & root_e[j][0]);
         r2  = h + ((signed'(XW'(zp1[0])) - cr) >>> 1);
         dbl = zx >>> 1;
         xa[j] = clip_word(xf.gt[j] ? r1 : dbl);
         xb[j] = clip_word(r2);
         if (!xf.has_z || (j == 1 && !xf.two_z)) begin
            cnt[j] = 2'd0;
         end else if (xf.gt[j]) begin
            cnt[j] = 2'd2;
         end else if (xf.eq[j]) begin
            cnt[j] = 2'd1;
         end else begin
            cnt[j] = 2'd0;
         end
      end
      for (int s = 0; s < ROOT_SLOTS; s++) begin
         slot[s] = '0;
      end
      // branch one fills the front, branch two follows it
      unique case (cnt[0])
         2'd2: begin
            slot[0] = xa[0];
            slot[1] = xb[0];
            slot[2] = xa[1];
            slot[3] = xb[1];
         end
         2'd1: begin
            slot[0] = xa[0];
            slot[1] = xa[1];
            slot[2] = xb[1];
         end
         default: begin
            slot[0] = xa[1];
            slot[1] = xb[1];
         end
      endcase
      count = COUNT_BITS'(cnt[0]) + COUNT_BITS'(cnt[1]);
      sat   = 1'b0;
      for (int s = 0; s < ROOT_SLOTS; s++) begin
         if (COUNT_BITS'(s) >= count) begin
            slot[s] = '0;
         end
         sat = sat | slot[s][W];
      end
   end

   logic [OUT_BITS-1:0] rsp_tdata_ff;
   logic                rsp_tuser_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         rsp_tvalid_ff <= xf.valid;
      end
      if (en) begin
         rsp_tuser_ff <= xf.st ? STATUS_NOT_SYM : STATUS_SOLVED;
         rsp_tdata_ff <= OUT_BITS'({sat, slot[3][W-1:0], slot[2][W-1:0],
                                    slot[1][W-1:0], slot[0][W-1:0], count});
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule
`default_nettype wire

[src/sqrr_checker.sv]
// Port-level checks of the symmetric quartic root solver, bound to its top level.
`default_nettype none
module sqrr_checker
   import sqrr_pkg::*;
#(
   parameter int WORD_BITS = 32
) (
   input wire logic                                          clock,
   input wire logic                                          reset,
   input wire logic                                          rsp_tvalid,
   input wire logic                                          rsp_tready,
   input wire logic [((4*WORD_BITS+COUNT_BITS+1+7)/8)*8-1:0] rsp_tdata,
   input wire logic                                          rsp_tuser
);

   localparam int W = WORD_BITS;

   logic [COUNT_BITS-1:0] count;
   logic [W-1:0]          root_2, root_4;

   assign count  = rsp_tdata[COUNT_BITS-1:0];
   assign root_2 = rsp_tdata[COUNT_BITS+2*W-1:COUNT_BITS+W];
   assign root_4 = rsp_tdata[COUNT_BITS+4*W-1:COUNT_BITS+3*W];

   a_not_sym_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STATUS_NOT_SYM |-> rsp_tdata == '0)
      else $error("not-symmetric word carries data");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> count <= COUNT_BITS'(ROOT_SLOTS))
      else $error("root count above four");

   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && count < COUNT_BITS'(ROOT_SLOTS) |->
         root_4 == '0 && (count > COUNT_BITS'(1) || root_2 == '0))
      else $error("root beyond count is not zero");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result word changed");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind symmetric_quartic_real_roots sqrr_checker #(.WORD_BITS(WORD_BITS)) u_sqrr_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
